[rtl/core/dpmq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package dpmq_pkg;

   // Depth of each message queue. Any value from 2 to 15 works.
   localparam int QUEUE_DEPTH = 8;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Depth of the command queue between the front and back ends.
   // It must be a power of two so that the pointers wrap on their own.
   localparam int CMDQ_DEPTH  = 2;
   localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);

   localparam int HANDLE_W    = 16;
   localparam int DWELL_W     = 16;
   localparam int TIME_W      = 32;
   localparam int ACTION_W    = 2;
   localparam int KIND_W      = 3;
   localparam int HCOUNT_W    = 5;

   // Action codes on the request channel.
   localparam logic [ACTION_W-1:0] ACT_ENQUEUE = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_SERVICE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_DRAIN   = 2'd2;

   // Result kinds on the response channel.
   localparam logic [KIND_W-1:0] KIND_QUEUED      = 3'd0;
   localparam logic [KIND_W-1:0] KIND_FULL        = 3'd1;
   localparam logic [KIND_W-1:0] KIND_HELD        = 3'd2;
   localparam logic [KIND_W-1:0] KIND_HIGH_SHOWN  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_LOW_SHOWN   = 3'd4;
   localparam logic [KIND_W-1:0] KIND_SHOW_CLOCK  = 3'd5;
   localparam logic [KIND_W-1:0] KIND_DRAIN_EMPTY = 3'd6;

   typedef enum logic [1:0] {
      OP_ENQUEUE,
      OP_SERVICE,
      OP_DRAIN
   } op_type;

   // One stored message.
   typedef struct packed {
      logic [HANDLE_W-1:0] handle;
      logic [DWELL_W-1:0]  dwell;
      logic                invert;
   } msg_type;

   // A classified command on its way from the front end to the back end.
   typedef struct packed {
      op_type            op;
      logic              low_prio;
      msg_type           msg;
      logic [TIME_W-1:0] now;
   } cmd_type;

endpackage

`default_nettype wire

[rtl/core/dual_priority_message_queue_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Strict-priority dual message queue. Requests enqueue a message (handle,
// dwell time, invert flag) into the high or low queue, service one message
// subject to the hold-off time, or drain both queues. A front end takes each
// request transfer, classifies it and parks it in a two-entry command queue;
// the back end owns both message FIFOs and the hold-off timer and writes one
// result per cycle into a response register while the response side does not
// stall. Enqueue and service each produce one result, so with no stall on the
// response side one request transfer is accepted every cycle. A drain emits
// one result per cycle while the response side does not stall, one per queued
// message (up to twice the queue depth), and the back end takes no further
// command until its last result has been loaded; requests keep arriving until
// the command queue fills. A command is written into the command queue and its
// result is then loaded into the response register, which drives response
// valid. An action code of 3 is accepted and produces no result. Reads of
// message storage only ever hit entries that were written, so the storage
// has no reset.

module dual_priority_message_queue_unit (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_valid,
   output logic                           req_stall,
   input  wire  [dpmq_pkg::ACTION_W-1:0]  req_action,
   input  wire                            req_priority_req,
   input  wire  [dpmq_pkg::HANDLE_W-1:0]  req_message_handle,
   input  wire  [dpmq_pkg::DWELL_W-1:0]   req_duration_ms,
   input  wire                            req_invert_display,
   input  wire  [dpmq_pkg::TIME_W-1:0]    req_now_ms,
   output logic                           rsp_valid,
   input  wire                            rsp_stall,
   output logic [dpmq_pkg::KIND_W-1:0]    rsp_result_kind,
   output logic [dpmq_pkg::HANDLE_W-1:0]  rsp_message_handle_out,
   output logic [dpmq_pkg::DWELL_W-1:0]   rsp_duration_out,
   output logic                           rsp_invert_out,
   output logic [dpmq_pkg::HCOUNT_W-1:0]  rsp_handled_count,
   output logic                           rsp_last
);
   import dpmq_pkg::*;

   // Command hand-off between the two halves.
   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd;

   // The front end accepts and classifies; it stalls only when its
   // command queue is full.
   dpmq_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_priority_req   (req_priority_req),
      .req_message_handle (req_message_handle),
      .req_duration_ms    (req_duration_ms),
      .req_invert_display (req_invert_display),
      .req_now_ms         (req_now_ms),
      .cmd_valid          (cmd_valid),
      .cmd                (cmd),
      .cmd_pop            (cmd_pop)
   );

   // The back end executes commands in order and drives the response
   // register, which refills in the same cycle that it is taken.
   dpmq_back u_back (
      .clock                  (clock),
      .reset                  (reset),
      .cmd_valid              (cmd_valid),
      .cmd                    (cmd),
      .cmd_pop                (cmd_pop),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_result_kind        (rsp_result_kind),
      .rsp_message_handle_out (rsp_message_handle_out),
      .rsp_duration_out       (rsp_duration_out),
      .rsp_invert_out         (rsp_invert_out),
      .rsp_handled_count      (rsp_handled_count),
      .rsp_last               (rsp_last)
   );

endmodule

`default_nettype wire

[rtl/core/dpmq_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module dpmq_front (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire  [dpmq_pkg::ACTION_W-1:0] req_action,
   input  wire                          req_priority_req,
   input  wire  [dpmq_pkg::HANDLE_W-1:0] req_message_handle,
   input  wire  [dpmq_pkg::DWELL_W-1:0]  req_duration_ms,
   input  wire                          req_invert_display,
   input  wire  [dpmq_pkg::TIME_W-1:0]   req_now_ms,
   output logic                         cmd_valid,
   output dpmq_pkg::cmd_type            cmd,
   input  wire                          cmd_pop
);
   import dpmq_pkg::*;

   cmd_type               cmdq_mem [CMDQ_DEPTH];
   logic [CMDQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_CNT_W-1:0] cnt_ff, cnt_in;
   cmd_type               new_cmd;
   logic                  keep;
   logic                  push;

   // Classify the request; the unused action code is taken and dropped.
   always_comb begin
      keep           = 1'b1;
      new_cmd.op     = OP_ENQUEUE;
      new_cmd.low_prio   = req_priority_req;
      new_cmd.msg.handle = req_message_handle;
      new_cmd.msg.dwell  = req_duration_ms;
      new_cmd.msg.invert = req_invert_display;
      new_cmd.now        = req_now_ms;
      case (req_action)
         ACT_ENQUEUE: new_cmd.op = OP_ENQUEUE;
         ACT_SERVICE: new_cmd.op = OP_SERVICE;
         ACT_DRAIN:   new_cmd.op = OP_DRAIN;
         default:     keep = 1'b0;
      endcase
   end

   assign req_stall = (cnt_ff == CMDQ_CNT_W'(CMDQ_DEPTH));
   assign push      = req_valid && !req_stall && keep;
   assign cmd_valid = (cnt_ff != '0);
   assign cmd       = cmdq_mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push    ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + CMDQ_CNT_W'(push) - CMDQ_CNT_W'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         cmdq_mem[wr_ptr_ff] <= new_cmd;
      end
   end

`ifndef SYNTHESIS
   a_cmdq_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CMDQ_CNT_W'(CMDQ_DEPTH))
      else $error("command queue count out of range");

   a_pop_only_when_valid: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("command popped from an empty queue");
`endif

endmodule

`default_nettype wire

[rtl/core/dpmq_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module dpmq_back (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            cmd_valid,
   input  wire dpmq_pkg::cmd_type         cmd,
   output logic                           cmd_pop,
   output logic                           rsp_valid,
   input  wire                            rsp_stall,
   output logic [dpmq_pkg::KIND_W-1:0]    rsp_result_kind,
   output logic [dpmq_pkg::HANDLE_W-1:0]  rsp_message_handle_out,
   output logic [dpmq_pkg::DWELL_W-1:0]   rsp_duration_out,
   output logic                           rsp_invert_out,
   output logic [dpmq_pkg::HCOUNT_W-1:0]  rsp_handled_count,
   output logic                           rsp_last
);
   import dpmq_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_DRAIN
   } state_type;

   msg_type high_mem [QUEUE_DEPTH];
   msg_type low_mem  [QUEUE_DEPTH];

   state_type            state_ff, state_in;
   logic [QPTR_W-1:0]    high_head_ff, high_head_in, high_tail_ff, high_tail_in;
   logic [QPTR_W-1:0]    low_head_ff, low_head_in, low_tail_ff, low_tail_in;
   logic [QCNT_W-1:0]    high_count_ff, high_count_in, low_count_ff, low_count_in;
   logic [TIME_W-1:0]    next_allowed_ff, next_allowed_in;
   logic [TIME_W-1:0]    drain_now_ff, drain_now_in;
   logic                 valid_ff, valid_in;
   logic [KIND_W-1:0]    kind_ff, kind_in;
   msg_type              msg_ff, msg_in;
   logic [HCOUNT_W-1:0]  hcount_ff, hcount_in;
   logic                 last_ff, last_in;

   logic                 out_free;
   logic                 high_has, low_has;
   logic                 single_left;
   logic                 do_pop, do_push;
   logic [TIME_W-1:0]    pop_now;
   msg_type              head_msg;

   function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
      ptr_next = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign out_free    = !valid_ff || !rsp_stall;
   assign high_has    = (high_count_ff != '0);
   assign low_has     = (low_count_ff != '0);
   assign single_left = ((QCNT_W+1)'(high_count_ff) + (QCNT_W+1)'(low_count_ff))
                        == (QCNT_W+1)'(1);
   assign head_msg    = high_has ? high_mem[high_head_ff] : low_mem[low_head_ff];

   always_comb begin
      state_in        = state_ff;
      high_head_in    = high_head_ff;
      high_tail_in    = high_tail_ff;
      high_count_in   = high_count_ff;
      low_head_in     = low_head_ff;
      low_tail_in     = low_tail_ff;
      low_count_in    = low_count_ff;
      next_allowed_in = next_allowed_ff;
      drain_now_in    = drain_now_ff;
      valid_in        = out_free ? 1'b0 : valid_ff;
      kind_in         = kind_ff;
      msg_in          = msg_ff;
      hcount_in       = hcount_ff;
      last_in         = last_ff;
      cmd_pop         = 1'b0;
      do_pop          = 1'b0;
      do_push         = 1'b0;
      pop_now         = drain_now_ff;

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_pop   = 1'b1;
               valid_in  = 1'b1;
               last_in   = 1'b1;
               msg_in    = '0;
               hcount_in = '0;
               pop_now   = cmd.now;
               case (cmd.op)
                  OP_ENQUEUE: begin
                     if (cmd.low_prio ? (low_count_ff < QCNT_W'(QUEUE_DEPTH))
                                      : (high_count_ff < QCNT_W'(QUEUE_DEPTH))) begin
                        do_push = 1'b1;
                        kind_in = KIND_QUEUED;
                     end else begin
                        kind_in = KIND_FULL;
                     end
                  end
                  OP_SERVICE: begin
                     if (cmd.now < next_allowed_ff) begin
                        kind_in = KIND_HELD;
                     end else if (high_has || low_has) begin
                        do_pop = 1'b1;
                     end else begin
                        kind_in = KIND_SHOW_CLOCK;
                     end
                  end
                  OP_DRAIN: begin
                     drain_now_in = cmd.now;
                     if (high_has || low_has) begin
                        do_pop    = 1'b1;
                        hcount_in = HCOUNT_W'(1);
                        last_in   = single_left;
                        if (!single_left) begin
                           state_in = ST_DRAIN;
                        end
                     end else begin
                        kind_in = KIND_DRAIN_EMPTY;
                     end
                  end
                  default: begin
                     kind_in = KIND_SHOW_CLOCK;
                  end
               endcase
            end
         end
         ST_DRAIN: begin
            if (out_free) begin
               valid_in  = 1'b1;
               do_pop    = 1'b1;
               hcount_in = hcount_ff + 1'b1;
               last_in   = single_left;
               if (single_left) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Pop the oldest message, high queue first.
      if (do_pop) begin
         msg_in          = head_msg;
         next_allowed_in = pop_now + TIME_W'(head_msg.dwell);
         if (high_has) begin
            kind_in       = KIND_HIGH_SHOWN;
            high_head_in  = ptr_next(high_head_ff);
            high_count_in = high_count_ff - 1'b1;
         end else begin
            kind_in       = KIND_LOW_SHOWN;
            low_head_in   = ptr_next(low_head_ff);
            low_count_in  = low_count_ff - 1'b1;
         end
      end

      if (do_push) begin
         if (cmd.low_prio) begin
            low_tail_in   = ptr_next(low_tail_ff);
            low_count_in  = low_count_ff + 1'b1;
         end else begin
            high_tail_in  = ptr_next(high_tail_ff);
            high_count_in = high_count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         high_head_ff    <= '0;
         high_tail_ff    <= '0;
         high_count_ff   <= '0;
         low_head_ff     <= '0;
         low_tail_ff     <= '0;
         low_count_ff    <= '0;
         next_allowed_ff <= '0;
         valid_ff        <= 1'b0;
      end else begin
         state_ff        <= state_in;
         high_head_ff    <= high_head_in;
         high_tail_ff    <= high_tail_in;
         high_count_ff   <= high_count_in;
         low_head_ff     <= low_head_in;
         low_tail_ff     <= low_tail_in;
         low_count_ff    <= low_count_in;
         next_allowed_ff <= next_allowed_in;
         valid_ff        <= valid_in;
      end
      drain_now_ff <= drain_now_in;
      kind_ff      <= kind_in;
      msg_ff       <= msg_in;
      hcount_ff    <= hcount_in;
      last_ff      <= last_in;
   end

   always_ff @(posedge clock) begin
      if (do_push && !cmd.low_prio) begin
         high_mem[high_tail_ff] <= cmd.msg;
      end
      if (do_push && cmd.low_prio) begin
         low_mem[low_tail_ff] <= cmd.msg;
      end
   end

   assign rsp_valid              = valid_ff;
   assign rsp_result_kind        = kind_ff;
   assign rsp_message_handle_out = msg_ff.handle;
   assign rsp_duration_out       = msg_ff.dwell;
   assign rsp_invert_out         = msg_ff.invert;
   assign rsp_handled_count      = hcount_ff;
   assign rsp_last               = last_ff;

`ifndef SYNTHESIS
   a_drain_has_work: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> (high_has || low_has))
      else $error("drain running with both queues empty");

   a_not_last_means_drain: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !last_ff) |-> (state_ff == ST_DRAIN))
      else $error("non-final result outside a drain");

   a_count_only_on_pop: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && hcount_ff != '0) |->
      (kind_ff == KIND_HIGH_SHOWN || kind_ff == KIND_LOW_SHOWN))
      else $error("handled count on a result that is not a pop");

   a_queue_bounds: assert property (@(posedge clock) disable iff (reset)
      (high_count_ff <= QCNT_W'(QUEUE_DEPTH)) && (low_count_ff <= QCNT_W'(QUEUE_DEPTH)))
      else $error("message queue count out of range");
`endif

endmodule

`default_nettype wire
